// ----- hw/rtl/rimt_pkg.sv -----
// Shared types and constants of the reversed interval merge table.
package rimt_pkg;

  localparam int unsigned PosW    = 31;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned ConfW   = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_IDX_SIGNAL_LENGTH = 1'b0;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_DRAIN = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_RANGE   = 3'd1;
  localparam logic [StatusW-1:0] ST_COVERED = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [PosW-1:0]   start_pos;
    logic [PosW-1:0]   end_pos;
    logic [LevelW-1:0] level;
    logic [ConfW-1:0]  conf;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic drain_en;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/rimt_cell.sv -----
// One table cell: holds an interval, compares it against the key, shifts with its neighbors.
module rimt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rimt_pkg::cell_ctrl_t ctrl_i,
  input  rimt_pkg::entry_t    key_i,
  input  rimt_pkg::entry_t    left_i,
  input  rimt_pkg::entry_t    right_i,
  input  logic                left_le_i,
  input  logic                occupied_i,
  input  logic                in_range_i,
  output rimt_pkg::entry_t    entry_o,
  output logic                le_o,
  output logic                ov_o
);
  import rimt_pkg::*;

  entry_t entry_q;
  logic   le_q, ov_q;

  // Insert opens a gap at the first cell whose start is above the key; cells past it
  // take their left neighbor. Drain moves every word one cell toward the head.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.drain_en) begin
      entry_q <= right_i;
    end else if (ctrl_i.ins_en && in_range_i && !le_q) begin
      entry_q <= left_le_i ? key_i : left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      le_q <= occupied_i && (entry_q.start_pos <= key_i.start_pos);
      ov_q <= occupied_i && (entry_q.start_pos <= key_i.end_pos)
                         && (entry_q.end_pos >= key_i.start_pos);
    end
  end

  assign entry_o = entry_q;
  assign le_o    = le_q;
  assign ov_o    = ov_q;

endmodule

// ----- hw/rtl/reversed_interval_merge_table_unit.sv -----
// Top level of the reversed interval merge table: a sorted row of interval cells.
//
// A load or merge word is taken in the idle state (a merge word is mirrored against
// signal_length), then every cell compares its interval with the key at once in S_CMP, and
// S_DEC reduces the overlap flags and shift-inserts across the cell row. A drain is accepted
// and then emits the stored entries in turn while the row shifts one cell toward the head
// per entry. An empty drain passes S_CMP and S_DEC and reports an empty status.
// The output register lets a new word be accepted while a result waits; stalls on the
// output stretch the decide and drain states. No reset sweep is needed.
module reversed_interval_merge_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rimt_pkg::AddrW-1:0]    paddr,
  input  logic [rimt_pkg::DataW-1:0]    pwdata,
  output logic [rimt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rimt_pkg::ModeW-1:0]    mode_i,
  input  logic [rimt_pkg::PosW-1:0]     ev_start_i,
  input  logic [rimt_pkg::PosW-1:0]     ev_end_i,
  input  logic [rimt_pkg::LevelW-1:0]   ev_level_i,
  input  logic [rimt_pkg::ConfW-1:0]    ev_confidence_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rimt_pkg::PosW-1:0]     out_start_o,
  output logic [rimt_pkg::PosW-1:0]     out_end_o,
  output logic [rimt_pkg::LevelW-1:0]   out_level_o,
  output logic [rimt_pkg::ConfW-1:0]    out_confidence_o,
  output logic [rimt_pkg::StatusW-1:0]  status_o,
  output logic                          last_o
);
  import rimt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PosW-1:0]      sig_len_q;
  mode_e                mode_q;
  logic                 rng_q;
  entry_t               key_q;
  logic                 out_valid_q;
  entry_t               out_word_q;
  logic [StatusW-1:0]   out_status_q;
  logic                 out_last_q;

  cell_ctrl_t           ctrl;
  logic                 emit;
  entry_t               emit_word;
  logic [StatusW-1:0]   emit_status;
  logic                 emit_last;
  logic                 in_fire, out_load, full;

  entry_t               cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_le, cell_ov;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_SIGNAL_LENGTH) ? {1'b0, sig_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_len_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_SIGNAL_LENGTH) begin
      sig_len_q <= pwdata[PosW-1:0];
    end
  end

  // ---------------- input capture ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = !out_valid_q || !out_stall_i;
  assign full       = (cnt_q == CntW'(TABLE_DEPTH));

  // Capture the word; a merge word's reversed interval is mirrored so that its start and end swap roles.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_e'(mode_i);
      rng_q  <= (ev_end_i > sig_len_q) || (ev_start_i > sig_len_q);
      if (mode_e'(mode_i) == MODE_MERGE) begin
        key_q.start_pos <= sig_len_q - ev_end_i;
        key_q.end_pos   <= sig_len_q - ev_start_i;
      end else begin
        key_q.start_pos <= ev_start_i;
        key_q.end_pos   <= ev_end_i;
      end
      key_q.level <= ev_level_i;
      key_q.conf  <= ev_confidence_i;
    end
  end

  // ---------------- cell row ----------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_w, right_w;
    logic   left_le_w;

    if (i == 0) begin : g_head
      assign left_w    = key_q;
      assign left_le_w = 1'b1;
    end else begin : g_body
      assign left_w    = cell_entry[i-1];
      assign left_le_w = cell_le[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_w = cell_entry[i];
    end else begin : g_mid
      assign right_w = cell_entry[i+1];
    end

    rimt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (key_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .left_le_i  (left_le_w),
      .occupied_i (CntW'(i) < cnt_q),
      .in_range_i (CntW'(i) <= cnt_q),
      .entry_o    (cell_entry[i]),
      .le_o       (cell_le[i]),
      .ov_o       (cell_ov[i])
    );
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl        = '0;
    emit        = 1'b0;
    emit_word   = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(mode_i))
            MODE_DRAIN: state_d = (cnt_q != '0) ? S_DRAIN : S_CMP;
            MODE_NONE:  state_d = S_IDLE;
            default:    state_d = S_CMP;
          endcase
        end
      end

      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = S_DEC;
      end

      S_DEC: begin
        // hold until the output register is free
        if (out_load) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          unique case (mode_q)
            MODE_LOAD: begin
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                ctrl.ins_en = 1'b1;
                emit_word   = key_q;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            MODE_MERGE: begin
              if (rng_q) begin
                emit_status = ST_RANGE;
              end else if (|cell_ov) begin
                emit_status = ST_COVERED;
              end else if (full) begin
                emit_status = ST_FULL;
              end else begin
                ctrl.ins_en = 1'b1;
                emit_word   = key_q;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            default: emit_status = ST_EMPTY;
          endcase
        end
      end

      S_DRAIN: begin
        if (out_load) begin
          emit          = 1'b1;
          emit_word     = cell_entry[0];
          emit_last     = (cnt_q == CntW'(1));
          ctrl.drain_en = 1'b1;
          cnt_d         = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q   <= emit_word;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_start_o      = out_word_q.start_pos;
  assign out_end_o        = out_word_q.end_pos;
  assign out_level_o      = out_word_q.level;
  assign out_confidence_o = out_word_q.conf;
  assign status_o         = out_status_q;
  assign last_o           = out_last_q;

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (cnt_q != '0))
    else $error("drain running on an empty table");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> (cnt_q == CntW'($past(cnt_q) + 1'b1)) && out_valid_q
                    && (status_o == ST_OK))
    else $error("insert did not grow the table by one");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.drain_en && cnt_q == CntW'(1)) |=> (state_q == S_IDLE) && (cnt_q == '0) && last_o)
    else $error("drain did not finish cleanly");

  for (genvar j = 0; j < TABLE_DEPTH - 1; j++) begin : g_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_IDLE && cnt_q > CntW'(j + 1))
        |-> (cell_entry[j].start_pos <= cell_entry[j+1].start_pos))
      else $error("table out of order");
  end

endmodule
